[rtl/core/three_wire_handshake_link_defines.svh]
// Assertion macros for the three-wire handshake link.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef THREE_WIRE_HANDSHAKE_LINK_DEFINES_SVH
`define THREE_WIRE_HANDSHAKE_LINK_DEFINES_SVH

// check that holds outside of reset
`define THWL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also holds while reset is applied
`define THWL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/thwl_pkg.sv]
// Shared types and constants of the three-wire handshake link.
// No dependencies; imported by thwl_cfg_regs and three_wire_handshake_link.
`default_nettype none

package thwl_pkg;

  localparam int unsigned WORD_BITS_DEF = 16;
  localparam int unsigned WAIT_W        = 11;
  localparam int unsigned SETUP_W       = 8;
  localparam int unsigned RETRY_W       = 3;
  localparam int unsigned APB_AW        = 5;
  localparam int unsigned APB_DW        = 32;
  localparam int unsigned PORT_WORD_W   = 16;

  typedef enum logic [3:0] {
    PH_RX_IDLE  = 4'd0,
    PH_RX_SYNC  = 4'd1,
    PH_RX_BLOW  = 4'd2,
    PH_RX_BHIGH = 4'd3,
    PH_RX_AWAIT = 4'd4,
    PH_RX_ASET  = 4'd5,
    PH_RX_ASTB  = 4'd6,
    PH_TX_SET   = 4'd7,
    PH_TX_START = 4'd8,
    PH_TX_SYNC  = 4'd9,
    PH_TX_BSET  = 4'd10,
    PH_TX_BLOW  = 4'd11,
    PH_TX_BHIGH = 4'd12,
    PH_TX_ESET  = 4'd13,
    PH_TX_EWAIT = 4'd14,
    PH_TX_EREL  = 4'd15
  } phase_e;

  typedef enum logic [2:0] {
    REG_TX_START_WAIT   = 3'd0,
    REG_TX_SYNC_WAIT    = 3'd1,
    REG_TX_BIT_WAIT     = 3'd2,
    REG_TX_SYNC_RETRIES = 3'd3,
    REG_RX_STROBE_WAIT  = 3'd4,
    REG_RX_EDGE_WAIT    = 3'd5,
    REG_SETUP_TICKS     = 3'd6,
    REG_UNUSED          = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [WAIT_W-1:0]  tx_start_wait;
    logic [WAIT_W-1:0]  tx_sync_wait;
    logic [WAIT_W-1:0]  tx_bit_wait;
    logic [RETRY_W-1:0] tx_sync_retries;
    logic [WAIT_W-1:0]  rx_strobe_wait;
    logic [WAIT_W-1:0]  rx_edge_wait;
    logic [SETUP_W-1:0] setup_ticks;
  } cfg_t;

  localparam logic [WAIT_W-1:0]  TX_START_WAIT_RST   = 11'd1200;
  localparam logic [WAIT_W-1:0]  TX_SYNC_WAIT_RST    = 11'd600;
  localparam logic [WAIT_W-1:0]  TX_BIT_WAIT_RST     = 11'd300;
  localparam logic [RETRY_W-1:0] TX_SYNC_RETRIES_RST = 3'd3;
  localparam logic [WAIT_W-1:0]  RX_STROBE_WAIT_RST  = 11'd620;
  localparam logic [WAIT_W-1:0]  RX_EDGE_WAIT_RST    = 11'd250;
  localparam logic [SETUP_W-1:0] SETUP_TICKS_RST     = 8'd12;

  localparam logic [7:0] KEY_HIGH_BYTE = 8'h55;
  localparam logic [7:0] KEY_LOW_MAX   = 8'h1B;

endpackage

`default_nettype wire

[rtl/core/thwl_cfg_regs.sv]
// APB register file holding the link timing configuration.
// Depends on thwl_pkg for the register map and cfg_t.
`default_nettype none

module thwl_cfg_regs import thwl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tx_start_wait   <= TX_START_WAIT_RST;
      cfg_q.tx_sync_wait    <= TX_SYNC_WAIT_RST;
      cfg_q.tx_bit_wait     <= TX_BIT_WAIT_RST;
      cfg_q.tx_sync_retries <= TX_SYNC_RETRIES_RST;
      cfg_q.rx_strobe_wait  <= RX_STROBE_WAIT_RST;
      cfg_q.rx_edge_wait    <= RX_EDGE_WAIT_RST;
      cfg_q.setup_ticks     <= SETUP_TICKS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_TX_START_WAIT:   cfg_q.tx_start_wait   <= pwdata[WAIT_W-1:0];
        REG_TX_SYNC_WAIT:    cfg_q.tx_sync_wait    <= pwdata[WAIT_W-1:0];
        REG_TX_BIT_WAIT:     cfg_q.tx_bit_wait     <= pwdata[WAIT_W-1:0];
        REG_TX_SYNC_RETRIES: cfg_q.tx_sync_retries <= pwdata[RETRY_W-1:0];
        REG_RX_STROBE_WAIT:  cfg_q.rx_strobe_wait  <= pwdata[WAIT_W-1:0];
        REG_RX_EDGE_WAIT:    cfg_q.rx_edge_wait    <= pwdata[WAIT_W-1:0];
        REG_SETUP_TICKS:     cfg_q.setup_ticks     <= pwdata[SETUP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_TX_START_WAIT:   prdata = APB_DW'(cfg_q.tx_start_wait);
      REG_TX_SYNC_WAIT:    prdata = APB_DW'(cfg_q.tx_sync_wait);
      REG_TX_BIT_WAIT:     prdata = APB_DW'(cfg_q.tx_bit_wait);
      REG_TX_SYNC_RETRIES: prdata = APB_DW'(cfg_q.tx_sync_retries);
      REG_RX_STROBE_WAIT:  prdata = APB_DW'(cfg_q.rx_strobe_wait);
      REG_RX_EDGE_WAIT:    prdata = APB_DW'(cfg_q.rx_edge_wait);
      REG_SETUP_TICKS:     prdata = APB_DW'(cfg_q.setup_ticks);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/three_wire_handshake_link.sv]
// A request accepted at one edge has its result valid after that edge.
// Throughput: one request per cycle unless a held result stalls; the phase/counter update
// is a single pass between the state registers and the result register.
// Reset (rst_ni low, async): receive idle, counters and shift words zero,
// no word held, timing registers at their defaults.
`default_nettype none

`include "three_wire_handshake_link_defines.svh"

module three_wire_handshake_link import thwl_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_AW-1:0]      paddr,
  input  wire logic [APB_DW-1:0]      pwdata,
  output logic      [APB_DW-1:0]      prdata,
  output logic                        pready,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   data_pin_i,
  input  wire logic                   strobe_pin_i,
  input  wire logic                   ack_pin_i,
  input  wire logic                   send_request_i,
  input  wire logic [PORT_WORD_W-1:0] send_word_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        data_drive_o,
  output logic                        data_level_o,
  output logic                        strobe_drive_o,
  output logic                        strobe_level_o,
  output logic                        ack_drive_o,
  output logic                        ack_level_o,
  output logic                        rx_valid_o,
  output logic      [PORT_WORD_W-1:0] rx_word_o,
  output logic                        rx_is_key_o,
  output logic                        tx_done_o,
  output logic                        tx_pending_o
);

  localparam int unsigned BCW = $clog2(WORD_BITS + 1);

  cfg_t cfg;

  thwl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  phase_e                  phase_q, phase_d;
  logic [WAIT_W-1:0]       wait_q, wait_d;
  logic [BCW-1:0]          bit_q, bit_d;
  logic [WORD_BITS-1:0]    rx_shift_q, rx_shift_d;
  logic [WORD_BITS-1:0]    tx_shift_q, tx_shift_d;
  logic [WORD_BITS-1:0]    rx_last_q, rx_last_d;
  logic [PORT_WORD_W-1:0]  tx_saved_q, tx_saved_d;
  logic [RETRY_W-1:0]      retry_q, retry_d;
  logic                    pend_q, pend_d;
  logic                    rxv_q, rxv_d;
  logic                    done_q, done_d;
  logic                    out_valid_q;
  logic                    in_fire;

  logic                    setup_done;
  logic [BCW-1:0]          bit_inc;
  logic [WAIT_W:0]         sync_cnt;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign setup_done = wait_q >= WAIT_W'(cfg.setup_ticks);
  assign bit_inc    = bit_q + BCW'(1);
  assign sync_cnt   = {1'b0, wait_q} + (WAIT_W+1)'(1);

  // next state for one tick
  always_comb begin
    phase_d    = phase_q;
    wait_d     = wait_q;
    bit_d      = bit_q;
    rx_shift_d = rx_shift_q;
    tx_shift_d = tx_shift_q;
    rx_last_d  = rx_last_q;
    tx_saved_d = tx_saved_q;
    retry_d    = retry_q;
    pend_d     = pend_q;
    rxv_d      = 1'b0;
    done_d     = 1'b0;

    // take a new word in any phase
    if (!pend_q && send_request_i && (send_word_i != '0)) begin
      tx_saved_d = send_word_i;
      pend_d     = 1'b1;
    end

    case (phase_q)
      PH_RX_IDLE: begin
        wait_d = '0;
        if (!data_pin_i) phase_d = PH_RX_SYNC;
        else if (pend_d) phase_d = PH_TX_SET;
      end
      PH_RX_SYNC: begin
        if (data_pin_i || wait_q >= cfg.rx_edge_wait) begin
          phase_d    = PH_RX_BLOW;
          wait_d     = '0;
          bit_d      = '0;
          rx_shift_d = '0;
        end else wait_d = wait_q + WAIT_W'(1);
      end
      PH_RX_BLOW: begin
        if (!strobe_pin_i || wait_q >= cfg.rx_strobe_wait) begin
          rx_shift_d = {rx_shift_q[WORD_BITS-2:0], data_pin_i};
          phase_d    = PH_RX_BHIGH;
          wait_d     = '0;
        end else wait_d = wait_q + WAIT_W'(1);
      end
      PH_RX_BHIGH: begin
        if (strobe_pin_i || wait_q >= cfg.rx_edge_wait) begin
          bit_d  = bit_inc;
          wait_d = '0;
          if (bit_inc >= BCW'(WORD_BITS)) begin
            rx_last_d = rx_shift_q;
            rxv_d     = 1'b1;
            phase_d   = PH_RX_AWAIT;
          end else phase_d = PH_RX_BLOW;
        end else wait_d = wait_q + WAIT_W'(1);
      end
      PH_RX_AWAIT: begin
        if (!ack_pin_i || wait_q >= cfg.rx_edge_wait) begin
          phase_d = PH_RX_ASET;
          wait_d  = '0;
        end else wait_d = wait_q + WAIT_W'(1);
      end
      PH_RX_ASET: begin
        if (setup_done) begin
          phase_d = PH_RX_ASTB;
          wait_d  = '0;
        end else wait_d = wait_q + WAIT_W'(1);
      end
      PH_RX_ASTB: begin
        if (ack_pin_i || wait_q >= cfg.rx_edge_wait) begin
          phase_d = PH_RX_IDLE;
          wait_d  = '0;
        end else wait_d = wait_q + WAIT_W'(1);
      end
      PH_TX_SET: begin
        if (setup_done) begin
          phase_d = PH_TX_START;
          wait_d  = '0;
        end else wait_d = wait_q + WAIT_W'(1);
      end
      PH_TX_START: begin
        if (!ack_pin_i) begin
          phase_d = PH_TX_SYNC;
          wait_d  = '0;
          retry_d = '0;
        end else if (wait_q >= cfg.tx_start_wait) begin
          phase_d = PH_RX_IDLE;
          wait_d  = '0;
        end else wait_d = wait_q + WAIT_W'(1);
      end
      PH_TX_SYNC: begin
        if (ack_pin_i) begin
          phase_d    = PH_TX_BSET;
          wait_d     = '0;
          bit_d      = '0;
          tx_shift_d = WORD_BITS'(tx_saved_d);
        end else if (sync_cnt >= {1'b0, cfg.tx_sync_wait}) begin
          wait_d = '0;
          if (retry_q >= cfg.tx_sync_retries) begin
            phase_d = PH_TX_SET;
            retry_d = '0;
          end else retry_d = retry_q + RETRY_W'(1);
        end else wait_d = wait_q + WAIT_W'(1);
      end
      PH_TX_BSET: begin
        if (setup_done) begin
          phase_d = PH_TX_BLOW;
          wait_d  = '0;
        end else wait_d = wait_q + WAIT_W'(1);
      end
      PH_TX_BLOW: begin
        if (wait_q >= cfg.tx_bit_wait) begin
          phase_d = PH_RX_IDLE;
          wait_d  = '0;
        end else if (!ack_pin_i) phase_d = PH_TX_BHIGH;
        else wait_d = wait_q + WAIT_W'(1);
      end
      PH_TX_BHIGH: begin
        if (wait_q >= cfg.tx_bit_wait) begin
          phase_d = PH_RX_IDLE;
          wait_d  = '0;
        end else if (ack_pin_i) begin
          tx_shift_d = {tx_shift_q[WORD_BITS-2:0], 1'b0};
          bit_d      = bit_inc;
          wait_d     = '0;
          phase_d    = (bit_inc >= BCW'(WORD_BITS)) ? PH_TX_ESET : PH_TX_BSET;
        end else wait_d = wait_q + WAIT_W'(1);
      end
      PH_TX_ESET: begin
        if (setup_done) begin
          phase_d = PH_TX_EWAIT;
          wait_d  = '0;
        end else wait_d = wait_q + WAIT_W'(1);
      end
      PH_TX_EWAIT: begin
        if (!strobe_pin_i) begin
          // data high from the partner is a positive end
          if (data_pin_i) begin
            pend_d = 1'b0;
            done_d = 1'b1;
          end
          phase_d = PH_TX_EREL;
          wait_d  = '0;
        end else if (wait_q >= cfg.tx_start_wait) begin
          phase_d = PH_RX_IDLE;
          wait_d  = '0;
        end else wait_d = wait_q + WAIT_W'(1);
      end
      PH_TX_EREL: begin
        if (setup_done) begin
          phase_d = PH_RX_IDLE;
          wait_d  = '0;
        end else wait_d = wait_q + WAIT_W'(1);
      end
      default: begin
        phase_d = PH_RX_IDLE;
        wait_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_RX_IDLE;
      wait_q     <= '0;
      bit_q      <= '0;
      rx_shift_q <= '0;
      tx_shift_q <= '0;
      rx_last_q  <= '0;
      tx_saved_q <= '0;
      retry_q    <= '0;
      pend_q     <= 1'b0;
      rxv_q      <= 1'b0;
      done_q     <= 1'b0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      wait_q     <= wait_d;
      bit_q      <= bit_d;
      rx_shift_q <= rx_shift_d;
      tx_shift_q <= tx_shift_d;
      rx_last_q  <= rx_last_d;
      tx_saved_q <= tx_saved_d;
      retry_q    <= retry_d;
      pend_q     <= pend_d;
      rxv_q      <= rxv_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // wire drives follow the phase held after the last tick
  always_comb begin
    data_drive_o   = 1'b0;
    data_level_o   = 1'b0;
    strobe_drive_o = 1'b0;
    strobe_level_o = 1'b0;
    ack_drive_o    = 1'b0;
    ack_level_o    = 1'b0;
    case (phase_q)
      PH_RX_IDLE, PH_RX_BLOW, PH_TX_ESET, PH_TX_EREL: begin
        ack_drive_o = 1'b1;
        ack_level_o = 1'b1;
      end
      PH_RX_SYNC, PH_RX_BHIGH, PH_TX_EWAIT: begin
        ack_drive_o = 1'b1;
      end
      PH_RX_ASET: begin
        data_drive_o = 1'b1;
        data_level_o = 1'b1;
      end
      PH_RX_ASTB: begin
        data_drive_o   = 1'b1;
        data_level_o   = 1'b1;
        strobe_drive_o = 1'b1;
      end
      PH_TX_SET, PH_TX_SYNC: begin
        data_drive_o   = 1'b1;
        data_level_o   = 1'b1;
        strobe_drive_o = 1'b1;
        strobe_level_o = 1'b1;
      end
      PH_TX_START: begin
        data_drive_o   = 1'b1;
        strobe_drive_o = 1'b1;
        strobe_level_o = 1'b1;
      end
      PH_TX_BSET, PH_TX_BHIGH: begin
        data_drive_o   = 1'b1;
        data_level_o   = tx_shift_q[WORD_BITS-1];
        strobe_drive_o = 1'b1;
        strobe_level_o = 1'b1;
      end
      PH_TX_BLOW: begin
        data_drive_o   = 1'b1;
        data_level_o   = tx_shift_q[WORD_BITS-1];
        strobe_drive_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign rx_valid_o   = rxv_q;
  assign tx_done_o    = done_q;
  assign tx_pending_o = pend_q;
  assign rx_word_o    = PORT_WORD_W'(rx_last_q);
  assign rx_is_key_o  = (rx_word_o[15:8] == KEY_HIGH_BYTE) && (rx_word_o[7:0] <= KEY_LOW_MAX);

  `THWL_ASSERT(a_done_clears_pending, out_valid_q && done_q |-> !pend_q, "tx_done with word still held")
  `THWL_ASSERT(a_rxv_in_await, out_valid_q && rxv_q |-> phase_q == PH_RX_AWAIT, "rx_valid outside ack wait")
  `THWL_ASSERT(a_stall_holds_state, out_valid_q && !out_ready_i |=> $stable(phase_q) && $stable(wait_q), "state moved while result stalled")
  `THWL_ASSERT(a_bit_count_range, bit_q <= BCW'(WORD_BITS), "bit count beyond word length")

endmodule

`default_nettype wire
